/* rtl/cod_pkg.sv */
package cod_pkg;

	// Field widths of the two channels
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned MASK_W     = 8;
	localparam int unsigned CHAN_IDX_W = 7;

	// Running offset register width
	localparam int unsigned OFFSET_W   = 18;

	// Byte counts of the channel framing
	localparam int unsigned ALIGN_BYTES     = 8;
	localparam int unsigned LEN_FIELD_BYTES = 2;

	typedef struct packed {
		logic [LEN_W-1:0]  length_word;
		logic [LEN_W-1:0]  payload_bytes;
		logic [MASK_W-1:0] unit_enable_mask;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_IDX_W-1:0] chan_index;
		logic                  offset_valid;
		logic [LEN_W-1:0]      chan_offset;
		logic                  fit_error;
		logic                  last_channel;
		logic                  all_found;
	} out_item_t;

endpackage

/* rtl/channel_offset_deframer_unit.sv */
// Channel offset deframer.
// Input channel (in_valid/in_ready/in_data): one item per readout channel, in
// channel order, carrying the length word read at the current offset, the
// payload length and the unit enable mask. Output channel (out_valid/
// out_ready/out_data): one result item per input item, giving the channel
// index, its start offset when valid, the sticky fit error, the last-channel
// mark and, on the last channel, whether every channel was accounted for.
// Each item passes through an input register and then a result register,
// with the offset adds, fit compares and 8-byte align between. Throughput
// is one item per cycle while the receiver takes results; the running offset,
// channel counters and valid count step with each result, so items may follow
// back to back. When the receiver stalls, the result register holds and the
// input register still takes one more item; after that in_ready drops until
// the result is taken. Reset (arst_n low) clears the pipeline and all event
// state; items are taken from the first clock edge after reset is released.
// After the last channel of an event the state returns to its reset value.
module channel_offset_deframer_unit #(
	parameter int unsigned CHANNELS_PER_UNIT = 12,
	parameter int unsigned NUM_UNITS         = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cod_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cod_pkg::out_item_t  out_data
);
	import cod_pkg::*;

	localparam int unsigned TOTAL_CHANNELS = CHANNELS_PER_UNIT * NUM_UNITS;
	localparam int unsigned CNT_W  = $clog2(TOTAL_CHANNELS + 1);
	localparam int unsigned POS_W  = (CHANNELS_PER_UNIT > 1) ? $clog2(CHANNELS_PER_UNIT) : 1;
	localparam int unsigned UNIT_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
	localparam int unsigned MASK_IDX_W = $clog2(MASK_W);
	localparam int unsigned SUM_W  = OFFSET_W + 1;

	localparam logic [CNT_W-1:0]  LAST_CHAN = CNT_W'(TOTAL_CHANNELS - 1);
	localparam logic [CNT_W-1:0]  TOTAL_CNT = CNT_W'(TOTAL_CHANNELS);
	localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(CHANNELS_PER_UNIT - 1);
	localparam logic [UNIT_W-1:0] LAST_UNIT = UNIT_W'(NUM_UNITS - 1);
	localparam logic [SUM_W-1:0]  ALIGN_MASK = SUM_W'(ALIGN_BYTES - 1);

	// Pipeline registers
	logic      valid_s1, valid_s2;
	in_item_t  item_s1;
	out_item_t item_s2;

	// Event state
	logic [OFFSET_W-1:0] offset_q;
	logic [CNT_W-1:0]    chan_q;
	logic [POS_W-1:0]    pos_q;
	logic [UNIT_W-1:0]   unit_q;
	logic                failed_q;
	logic [CNT_W-1:0]    valid_cnt_q;

	logic advance_s2, advance_s1;

	// Step logic
	logic                  unit_en, is_last, unit_end, chan_fail, chan_ok;
	logic [SUM_W-1:0]      sum_len, sum_hdr, end_off;
	logic [CNT_W-1:0]      valid_cnt_d;
	logic                  failed_d;
	logic [OFFSET_W-1:0]   offset_d;
	out_item_t             result;

	assign advance_s2 = !valid_s2 || out_ready;
	assign advance_s1 = valid_s1 && advance_s2;
	assign in_ready   = !valid_s1 || advance_s2;
	assign out_valid  = valid_s2;
	assign out_data   = item_s2;

	// Check the channel against the payload and work out the next offset
	always_comb begin
		unit_en  = item_s1.unit_enable_mask[MASK_IDX_W'(unit_q)];
		is_last  = (chan_q == LAST_CHAN);
		unit_end = (pos_q == LAST_POS);
		sum_len  = SUM_W'(offset_q) + SUM_W'(item_s1.length_word);
		sum_hdr  = SUM_W'(offset_q) + SUM_W'(LEN_FIELD_BYTES);
		chan_fail = (sum_hdr >= SUM_W'(item_s1.payload_bytes)) ||
			(sum_len > SUM_W'(item_s1.payload_bytes));
		chan_ok  = !failed_q && unit_en && !chan_fail;
		end_off  = unit_end ? ((sum_len + ALIGN_MASK) & ~ALIGN_MASK) : sum_len;

		failed_d    = failed_q || (unit_en && chan_fail);
		valid_cnt_d = valid_cnt_q;
		offset_d    = offset_q;
		if (!failed_q && (!unit_en || !chan_fail)) begin
			valid_cnt_d = valid_cnt_q + CNT_W'(1);
		end
		if (chan_ok) begin
			offset_d = end_off[OFFSET_W-1:0];
		end

		result.chan_index   = CHAN_IDX_W'(chan_q);
		result.offset_valid = chan_ok;
		result.chan_offset  = chan_ok ? offset_q[LEN_W-1:0] : '0;
		result.fit_error    = failed_d;
		result.last_channel = is_last;
		result.all_found    = is_last && (valid_cnt_d == TOTAL_CNT);
	end

	// Hold or advance the pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture payloads
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance_s1) begin
			item_s2 <= result;
		end
	end

	// Advance the event state once per item; clear it after the last channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			chan_q      <= '0;
			pos_q       <= '0;
			unit_q      <= '0;
			failed_q    <= 1'b0;
			valid_cnt_q <= '0;
		end else if (advance_s1) begin
			if (is_last) begin
				offset_q    <= '0;
				chan_q      <= '0;
				pos_q       <= '0;
				unit_q      <= '0;
				failed_q    <= 1'b0;
				valid_cnt_q <= '0;
			end else begin
				offset_q    <= offset_d;
				chan_q      <= chan_q + CNT_W'(1);
				failed_q    <= failed_d;
				valid_cnt_q <= valid_cnt_d;
				if (unit_end) begin
					pos_q <= '0;
					if (unit_q != LAST_UNIT) begin
						unit_q <= unit_q + UNIT_W'(1);
					end
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_offset_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.offset_valid |-> out_data.chan_offset == '0)
		else $error("invalid channel carries a non-zero offset");

	a_all_found_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.all_found |-> out_data.last_channel)
		else $error("all_found raised away from the last channel");

	a_valid_excludes_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.offset_valid |-> !out_data.fit_error)
		else $error("valid channel reported with fit error set");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_cnt_q <= chan_q)
		else $error("valid count ahead of channel count");
`endif

endmodule
